FILE: hdl/mpscan_pkg.sv
// Shared types, codes and constants of the masked pattern scan block.
package mpscan_pkg;

   localparam int MaxPatternDefault  = 16;
   localparam int MaxSectionsDefault = 16;
   localparam int PatternBytes       = 16;
   localparam int CsrIndexWidth      = 3;
   localparam int CsrDataWidth       = 64;

   typedef enum logic {
      CMD_LOAD_SECTION = 1'b0,
      CMD_FILE_BYTE    = 1'b1
   } command_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_PATTERN_LOW    = 3'd0,
      CSR_PATTERN_HIGH   = 3'd1,
      CSR_CARE_MASK      = 3'd2,
      CSR_PATTERN_LENGTH = 3'd3,
      CSR_SECTION_COUNT  = 3'd4
   } csr_index_type;

   typedef enum logic {
      WALK_IDLE = 1'b0,
      WALK_RUN  = 1'b1
   } walk_state_type;

   typedef struct packed {
      logic [31:0] virtual_base;
      logic [31:0] virtual_size;
      logic [31:0] raw_base;
   } section_entry_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [31:0] position;
      logic [31:0] adjusted;
   } walk_status_type;

endpackage

FILE: hdl/mpscan_ifs.sv
// Valid/ready channel interfaces for the request and response sides of the scanner.
interface mpscan_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [3:0]  section_index;
   logic [31:0] section_virtual_base;
   logic [31:0] section_virtual_size;
   logic [31:0] section_raw_base;
   logic [7:0]  data_byte;
   logic        last_byte;

   modport source (
      output valid, command, section_index, section_virtual_base,
             section_virtual_size, section_raw_base, data_byte, last_byte,
      input  ready
   );
   modport sink (
      input  valid, command, section_index, section_virtual_base,
             section_virtual_size, section_raw_base, data_byte, last_byte,
      output ready
   );
endinterface

interface mpscan_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [31:0] match_position;
   logic [31:0] adjusted_address;

   modport source (
      output valid, found, match_position, adjusted_address,
      input  ready
   );
   modport sink (
      input  valid, found, match_position, adjusted_address,
      output ready
   );
endinterface

FILE: hdl/mpscan_section_walk.sv
// Section table memory and the sequencer that walks it to translate a match position.
module mpscan_section_walk
   import mpscan_pkg::*;
#(
   parameter int MAX_SECTIONS = MaxSectionsDefault,
   localparam int SecAw = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1,
   localparam int CntW  = $clog2(MAX_SECTIONS + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              load_en,
   input  logic [SecAw-1:0]  load_slot,
   input  section_entry_type load_entry,
   input  logic              start,
   input  logic [31:0]       start_position,
   input  logic [CntW-1:0]   count,
   output walk_status_type   status
);

   section_entry_type mem [MAX_SECTIONS];
   section_entry_type rd_entry_ff;

   walk_state_type    state_ff, state_in;
   logic [CntW-1:0]   walk_idx_ff, walk_idx_in;
   logic              pend_ff, pend_in;
   logic [31:0]       pos_ff, pos_in;

   logic              issue;
   logic              hit;
   logic              done;
   logic [31:0]       range_end;
   logic [SecAw-1:0]  rd_addr;

   // Loads are only accepted while the walk is idle, so a write never meets a read.
   always_ff @(posedge clock) begin
      if (load_en) begin
         mem[load_slot] <= load_entry;
      end
      if (issue) begin
         rd_entry_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= WALK_IDLE;
         walk_idx_ff <= '0;
         pend_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         walk_idx_ff <= walk_idx_in;
         pend_ff     <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
   end

   assign rd_addr   = walk_idx_ff[SecAw-1:0];
   assign range_end = rd_entry_ff.virtual_base + rd_entry_ff.virtual_size;
   assign hit       = pend_ff && (pos_ff >= rd_entry_ff.virtual_base) && (pos_ff < range_end);

   always_comb begin
      state_in    = state_ff;
      walk_idx_in = walk_idx_ff;
      pend_in     = 1'b0;
      pos_in      = pos_ff;
      issue       = 1'b0;
      done        = 1'b0;
      case (state_ff)
         WALK_IDLE: begin
            if (start) begin
               state_in    = WALK_RUN;
               walk_idx_in = '0;
               pos_in      = start_position;
            end
         end
         WALK_RUN: begin
            issue = (walk_idx_ff < count);
            done  = hit || !issue;
            if (issue) begin
               walk_idx_in = walk_idx_ff + CntW'(1);
            end
            pend_in = issue && !done;
            if (done) begin
               state_in = WALK_IDLE;
            end
         end
         default: begin
            state_in = WALK_IDLE;
         end
      endcase
   end

   // Twice the position minus the translated offset reduces to p + base - raw.
   always_comb begin
      status.busy     = (state_ff == WALK_RUN);
      status.done     = done;
      status.position = pos_ff;
      status.adjusted = hit ? (pos_ff + rd_entry_ff.virtual_base - rd_entry_ff.raw_base)
                            : pos_ff;
   end

endmodule

FILE: hdl/masked_pattern_scan_with_section_map.sv
// Top level of the masked byte pattern scanner with section address translation.
//
// Usage: the req_bus channel carries two kinds of transaction. A load transaction
// (command low) writes one entry of the section table; a byte transaction
// (command high) delivers the next file byte, with last_byte marking the end of
// the file. The csr port sets the pattern, care mask, pattern length and section
// count; it must be written only while the block is idle, and the block does
// not enforce this. Throughput: one transaction per cycle while scanning, unless
// a waiting result holds req_bus.ready low. On the first match the block walks
// the section table memory, one entry per cycle through a registered read, until
// an entry holds the position or section_count entries have been read;
// req_bus.ready is low during the walk. A match result appears on rsp_bus in the
// cycle after the walk ends; a not-found result appears in the cycle after the
// last byte is accepted.
// The result sits in an output register. While it waits, the block keeps taking
// transactions that cannot produce a result (bytes after a match); otherwise it
// holds req_bus.ready low until rsp_bus.ready drains the register.
// Reset (synchronous, active high) loads the register defaults and rearms the
// search; the section table holds no defined data until loaded.
module masked_pattern_scan_with_section_map
   import mpscan_pkg::*;
#(
   parameter int MAX_PATTERN  = MaxPatternDefault,
   parameter int MAX_SECTIONS = MaxSectionsDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   mpscan_req_if.sink               req_bus,
   mpscan_rsp_if.source             rsp_bus,
   input  logic                     csr_wr_en,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   localparam int LenW  = $clog2(MAX_PATTERN + 1);
   localparam int SecAw = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
   localparam int CntW  = $clog2(MAX_SECTIONS + 1);

   // Configuration registers.
   logic [63:0] pattern_low_ff;
   logic [63:0] pattern_high_ff;
   logic [15:0] care_mask_ff;
   logic [4:0]  pattern_length_ff;
   logic [4:0]  section_count_ff;

   // Search state. The window bytes need no reset because the fill count
   // decides which of them take part in a compare.
   logic [MAX_PATTERN-1:0][7:0] window_ff, window_in;
   logic [31:0]                 position_ff, position_in;
   logic [LenW-1:0]             fill_ff, fill_in;
   logic                        search_done_ff, search_done_in;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_found_ff, rsp_found_in;
   logic [31:0] rsp_position_ff, rsp_position_in;
   logic [31:0] rsp_adjusted_ff, rsp_adjusted_in;

   logic [PatternBytes-1:0][7:0] pattern_bytes;
   logic [LenW-1:0]              eff_len;
   logic [CntW-1:0]              eff_count;
   logic [LenW-1:0]              fill_next;
   logic [MAX_PATTERN-1:0][7:0]  shifted;
   logic                         mismatch;
   logic                         match;
   logic                         req_fire;
   logic                         is_byte;
   logic                         walk_start;
   logic [31:0]                  match_pos;
   logic                         load_en;
   section_entry_type            load_entry;
   walk_status_type              walk_status;

   assign pattern_bytes = {pattern_high_ff, pattern_low_ff};

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         care_mask_ff      <= 16'hFFFF;
         pattern_length_ff <= 5'd1;
         section_count_ff  <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PATTERN_LOW:    pattern_low_ff    <= csr_wdata;
            CSR_PATTERN_HIGH:   pattern_high_ff   <= csr_wdata;
            CSR_CARE_MASK:      care_mask_ff      <= csr_wdata[15:0];
            CSR_PATTERN_LENGTH: pattern_length_ff <= csr_wdata[4:0];
            CSR_SECTION_COUNT:  section_count_ff  <= csr_wdata[4:0];
            default: begin
            end
         endcase
      end
   end

   // Length and count are clamped into the range the hardware supports.
   always_comb begin
      if (pattern_length_ff == 5'd0) begin
         eff_len = LenW'(1);
      end else if (int'(pattern_length_ff) > MAX_PATTERN) begin
         eff_len = LenW'(MAX_PATTERN);
      end else begin
         eff_len = LenW'(pattern_length_ff);
      end
      if (int'(section_count_ff) > MAX_SECTIONS) begin
         eff_count = CntW'(MAX_SECTIONS);
      end else begin
         eff_count = CntW'(section_count_ff);
      end
   end

   assign req_fire = req_bus.valid && req_bus.ready;
   assign is_byte  = (req_bus.command == CMD_FILE_BYTE);
   assign req_bus.ready = !walk_status.busy &&
                          (!rsp_valid_ff || rsp_bus.ready || search_done_ff);

   // Window with the new byte shifted in, newest byte at the top.
   always_comb begin
      for (int i = 0; i < MAX_PATTERN - 1; i++) begin
         shifted[i] = window_ff[i + 1];
      end
      shifted[MAX_PATTERN-1] = req_bus.data_byte;
   end

   assign fill_next = (fill_ff == LenW'(MAX_PATTERN)) ? fill_ff : fill_ff + LenW'(1);

   // Window byte i lines up with pattern byte i + len - MAX_PATTERN. Pattern
   // bytes past the pattern registers are wildcards.
   always_comb begin
      int         jj;
      logic [3:0] sel;
      mismatch = 1'b0;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         jj  = i + int'(eff_len) - MAX_PATTERN;
         sel = jj[3:0];
         if (jj >= 0 && jj < PatternBytes) begin
            if (care_mask_ff[sel] && (shifted[i] != pattern_bytes[sel])) begin
               mismatch = 1'b1;
            end
         end
      end
   end

   assign match     = (fill_next >= eff_len) && !mismatch;
   assign match_pos = position_ff - 32'(eff_len) + 32'd1;

   assign walk_start = req_fire && is_byte && !search_done_ff && match;

   assign load_en = req_fire && !is_byte && (int'(req_bus.section_index) < MAX_SECTIONS);
   assign load_entry = '{virtual_base: req_bus.section_virtual_base,
                         virtual_size: req_bus.section_virtual_size,
                         raw_base:     req_bus.section_raw_base};

   mpscan_section_walk #(
      .MAX_SECTIONS (MAX_SECTIONS)
   ) u_walk (
      .clock          (clock),
      .reset          (reset),
      .load_en        (load_en),
      .load_slot      (SecAw'(req_bus.section_index)),
      .load_entry     (load_entry),
      .start          (walk_start),
      .start_position (match_pos),
      .count          (eff_count),
      .status         (walk_status)
   );

   // Search state and output register updates.
   always_comb begin
      window_in       = window_ff;
      position_in     = position_ff;
      fill_in         = fill_ff;
      search_done_in  = search_done_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_bus.ready;
      rsp_found_in    = rsp_found_ff;
      rsp_position_in = rsp_position_ff;
      rsp_adjusted_in = rsp_adjusted_ff;

      if (req_fire && is_byte) begin
         if (!search_done_ff) begin
            window_in   = shifted;
            position_in = position_ff + 32'd1;
            fill_in     = fill_next;
            if (match) begin
               search_done_in = 1'b1;
            end else if (req_bus.last_byte) begin
               rsp_valid_in    = 1'b1;
               rsp_found_in    = 1'b0;
               rsp_position_in = '0;
               rsp_adjusted_in = '0;
            end
         end
         // The last byte always rearms for the next file.
         if (req_bus.last_byte) begin
            position_in    = '0;
            fill_in        = '0;
            search_done_in = 1'b0;
         end
      end

      if (walk_status.done) begin
         rsp_valid_in    = 1'b1;
         rsp_found_in    = 1'b1;
         rsp_position_in = walk_status.position;
         rsp_adjusted_in = walk_status.adjusted;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff    <= '0;
         fill_ff        <= '0;
         search_done_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         position_ff    <= position_in;
         fill_ff        <= fill_in;
         search_done_ff <= search_done_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      window_ff       <= window_in;
      rsp_found_ff    <= rsp_found_in;
      rsp_position_ff <= rsp_position_in;
      rsp_adjusted_ff <= rsp_adjusted_in;
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.found            = rsp_found_ff;
   assign rsp_bus.match_position   = rsp_position_ff;
   assign rsp_bus.adjusted_address = rsp_adjusted_ff;

   // No transaction may be accepted while the section walk owns the table.
   a_no_accept_in_walk: assert property (@(posedge clock) disable iff (reset)
      walk_status.busy |-> !req_fire)
      else $error("transaction accepted during section walk");

   // A finished walk must find the output register free or draining.
   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      walk_status.done |-> (!rsp_valid_ff || rsp_bus.ready))
      else $error("walk result would overwrite a pending response");

   // A walk only completes while it is running.
   a_done_while_busy: assert property (@(posedge clock) disable iff (reset)
      walk_status.done |-> walk_status.busy)
      else $error("walk done outside of a walk");

   // Starting a walk puts the block into the busy state on the next cycle.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      walk_start |=> walk_status.busy)
      else $error("walk did not start after a match");

   // Once a match is recorded, further bytes of the file start no walk.
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      (req_fire && search_done_ff) |-> !walk_start)
      else $error("second match reported for one file");

endmodule
